@@ rtl/core/bba_pkg.sv @@
package bba_pkg;

    // Register indexes on the configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRANULE_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ORDER    = 1'd1;
    localparam int CFG_DATA_W = 5;

    // Field widths fixed by the interface.
    localparam int SIZE_W = 26;
    localparam int ADDR_W = 27;
    localparam int ORDF_W = 4;
    localparam int STAT_W = 2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_ADDR  = 2'd3;

    // Item opcodes.
    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_K_STEP,
        OP_I_INIT,
        OP_I_STEP,
        OP_POP_RD,
        OP_POP_TAKE,
        OP_SPLIT,
        OP_ALLOC_DONE,
        OP_ORD_RD,
        OP_ORD_TAKE,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_LAST_RD,
        OP_SWAP,
        OP_PUSH_DONE,
        OP_ERR
    } bba_op_t;

    typedef struct packed {
        bba_op_t             op;
        logic [STAT_W-1:0]   err;
    } bba_cmd_t;

    typedef struct packed {
        logic is_free;
        logic too_large;
        logic k_more;
        logic i_over;
        logic cnt_zero;
        logic i_gt_k;
        logic bad_addr;
        logic o_gt_t;
        logic o_lt_t;
        logic j_lt_cnt;
        logic match;
    } bba_sts_t;

endpackage

@@ rtl/core/bba_dpath.sv @@
module bba_dpath
    import bba_pkg::*;
#(
    parameter int MAX_ORDER = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  bba_cmd_t              cmd,
    input  logic                  opcode,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [ADDR_W-1:0]     user_address,
    output bba_sts_t              sts,
    output logic [ADDR_W-1:0]     result_address,
    output logic [ORDF_W-1:0]     block_order,
    output logic [STAT_W-1:0]     status
);

    localparam int NBLK = 1 << MAX_ORDER;
    localparam int OW   = $clog2(MAX_ORDER + 1);
    localparam int CW   = MAX_ORDER + 1;
    localparam int SW   = $clog2(MAX_ORDER + 17);
    localparam int SAW  = OW + MAX_ORDER;
    localparam logic [OW-1:0] TOP_RST = OW'((MAX_ORDER < 10) ? MAX_ORDER : 10);
    localparam logic [CW-1:0] CNT_FULL = CW'(NBLK);

    logic [4:0]           gran_reg;
    logic [3:0]           top_reg;
    logic                 opc_reg;
    logic [SIZE_W-1:0]    req_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [OW-1:0]        k_reg, i_reg, o_reg;
    logic [CW-1:0]        j_reg;
    logic [MAX_ORDER-1:0] blk_reg;
    logic [MAX_ORDER-1:0] rd_reg;
    logic [OW-1:0]        ord_rd_reg;
    logic [CW-1:0]        cnt_reg [MAX_ORDER+1];
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [ORDF_W-1:0]    res_ord_reg;
    logic [STAT_W-1:0]    res_st_reg;

    logic [MAX_ORDER-1:0] stack_mem [(MAX_ORDER+1)*NBLK];
    logic [OW-1:0]        oob_mem [NBLK];

    logic [4:0]           eff_g;
    logic [OW-1:0]        eff_t, init_top;
    logic                 init_now;
    logic [SW-1:0]        sh_gt, sh_gk;
    logic [ADDR_W-1:0]    off;
    logic [MAX_ORDER-1:0] fblk, one, buddy;
    logic [CW-1:0]        cnt_i, cnt_o, cnt_d;
    logic [OW-1:0]        i_dec;
    logic                 st_we, st_re, cnt_we;
    logic [SAW-1:0]       st_waddr, st_raddr;
    logic [MAX_ORDER-1:0] st_wdata;
    logic [OW-1:0]        cnt_widx;
    logic [CW-1:0]        cnt_wval;

    assign eff_g = (gran_reg > 5'd16) ? 5'd16 : gran_reg;
    assign eff_t = (int'(top_reg) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(top_reg);

    always_comb
    begin
        init_top = eff_t;
        if (cfg_we && cfg_index == REG_TOP_ORDER)
        begin
            init_top = (int'(cfg_data[3:0]) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(cfg_data[3:0]);
        end
    end

    assign init_now = (cfg_we && (cfg_index == REG_GRANULE_LOG2 || cfg_index == REG_TOP_ORDER))
                      || cmd.op == OP_INIT;

    assign sh_gt = SW'(eff_g) + SW'(eff_t);
    assign sh_gk = SW'(eff_g) + SW'(k_reg);
    assign off   = addr_reg - ADDR_W'(1);
    assign fblk  = MAX_ORDER'(off >> eff_g);
    assign one   = MAX_ORDER'(1);
    assign buddy = blk_reg ^ (one << o_reg);
    assign i_dec = i_reg - OW'(1);
    assign cnt_i = (int'(i_reg) > MAX_ORDER) ? '0 : cnt_reg[i_reg];
    assign cnt_o = (int'(o_reg) > MAX_ORDER) ? '0 : cnt_reg[o_reg];
    assign cnt_d = (int'(i_dec) > MAX_ORDER) ? '0 : cnt_reg[i_dec];

    always_comb
    begin
        sts.is_free   = opc_reg == OPC_FREE;
        sts.too_large = (req_reg >> sh_gt) != '0;
        sts.k_more    = (req_reg >> sh_gk) != '0;
        sts.i_over    = i_reg > eff_t;
        sts.cnt_zero  = cnt_i == '0;
        sts.i_gt_k    = i_reg > k_reg;
        sts.bad_addr  = addr_reg == '0 || (off >> sh_gt) != '0
                        || (off & ~({ADDR_W{1'b1}} << eff_g)) != '0;
        sts.o_gt_t    = o_reg > eff_t;
        sts.o_lt_t    = o_reg < eff_t;
        sts.j_lt_cnt  = j_reg < cnt_o;
        sts.match     = rd_reg == buddy;
    end

    // Stack memory and count update selection.
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_re    = 1'b0;
        st_raddr = '0;
        cnt_we   = 1'b0;
        cnt_widx = '0;
        cnt_wval = '0;
        if (init_now)
        begin
            st_we    = 1'b1;
            st_waddr = {init_top, {MAX_ORDER{1'b0}}};
        end
        else
        begin
            case (cmd.op)
                OP_POP_RD:
                begin
                    st_re    = 1'b1;
                    st_raddr = {i_reg, MAX_ORDER'(cnt_i - CW'(1))};
                    cnt_we   = 1'b1;
                    cnt_widx = i_reg;
                    cnt_wval = cnt_i - CW'(1);
                end
                OP_SPLIT:
                begin
                    if (cnt_d < CNT_FULL)
                    begin
                        st_we    = 1'b1;
                        st_waddr = {i_dec, cnt_d[MAX_ORDER-1:0]};
                        st_wdata = blk_reg + (one << i_dec);
                        cnt_we   = 1'b1;
                        cnt_widx = i_dec;
                        cnt_wval = cnt_d + CW'(1);
                    end
                end
                OP_SCAN_RD:
                begin
                    st_re    = 1'b1;
                    st_raddr = {o_reg, j_reg[MAX_ORDER-1:0]};
                end
                OP_LAST_RD:
                begin
                    st_re    = 1'b1;
                    st_raddr = {o_reg, MAX_ORDER'(cnt_o - CW'(1))};
                end
                OP_SWAP:
                begin
                    st_we    = 1'b1;
                    st_waddr = {o_reg, j_reg[MAX_ORDER-1:0]};
                    st_wdata = rd_reg;
                    cnt_we   = 1'b1;
                    cnt_widx = o_reg;
                    cnt_wval = cnt_o - CW'(1);
                end
                OP_PUSH_DONE:
                begin
                    if (cnt_o < CNT_FULL)
                    begin
                        st_we    = 1'b1;
                        st_waddr = {o_reg, cnt_o[MAX_ORDER-1:0]};
                        st_wdata = blk_reg;
                        cnt_we   = 1'b1;
                        cnt_widx = o_reg;
                        cnt_wval = cnt_o + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            rd_reg <= stack_mem[st_raddr];
        end
        if (cmd.op == OP_ALLOC_DONE)
        begin
            oob_mem[blk_reg] <= k_reg;
        end
        if (cmd.op == OP_ORD_RD)
        begin
            ord_rd_reg <= oob_mem[fblk];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gran_reg <= 5'd4;
            top_reg  <= 4'd10;
            for (int n = 0; n <= MAX_ORDER; n++)
            begin
                cnt_reg[n] <= (n == int'(TOP_RST)) ? CW'(1) : '0;
            end
        end
        else
        begin
            if (cfg_we && cfg_index == REG_GRANULE_LOG2)
            begin
                gran_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_TOP_ORDER)
            begin
                top_reg <= cfg_data[3:0];
            end
            if (init_now)
            begin
                for (int n = 0; n <= MAX_ORDER; n++)
                begin
                    cnt_reg[n] <= (n == int'(init_top)) ? CW'(1) : '0;
                end
            end
            else if (cnt_we)
            begin
                cnt_reg[cnt_widx] <= cnt_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                opc_reg  <= opcode;
                req_reg  <= request_size;
                addr_reg <= user_address;
                k_reg    <= '0;
            end
            OP_K_STEP:    k_reg   <= k_reg + OW'(1);
            OP_I_INIT:    i_reg   <= k_reg;
            OP_I_STEP:    i_reg   <= i_reg + OW'(1);
            OP_POP_TAKE:  blk_reg <= rd_reg;
            OP_SPLIT:     i_reg   <= i_dec;
            OP_ORD_TAKE:
            begin
                o_reg   <= ord_rd_reg;
                blk_reg <= fblk;
            end
            OP_SCAN_INIT: j_reg   <= '0;
            OP_SCAN_NEXT: j_reg   <= j_reg + CW'(1);
            OP_SWAP:
            begin
                if (buddy < blk_reg)
                begin
                    blk_reg <= buddy;
                end
                o_reg <= o_reg + OW'(1);
            end
            OP_ALLOC_DONE:
            begin
                res_addr_reg <= ({{(ADDR_W-MAX_ORDER){1'b0}}, blk_reg} << eff_g) + ADDR_W'(1);
                res_ord_reg  <= ORDF_W'(k_reg);
                res_st_reg   <= ST_OK;
            end
            OP_PUSH_DONE:
            begin
                res_addr_reg <= '0;
                res_ord_reg  <= ORDF_W'(o_reg);
                res_st_reg   <= ST_OK;
            end
            OP_ERR:
            begin
                res_addr_reg <= '0;
                res_ord_reg  <= '0;
                res_st_reg   <= cmd.err;
            end
            default:
            begin
            end
        endcase
    end

    assign result_address = res_addr_reg;
    assign block_order    = res_ord_reg;
    assign status         = res_st_reg;

endmodule

@@ rtl/core/bba_ctrl.sv @@
module bba_ctrl
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  bba_sts_t sts,
    output bba_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_CHK,
        S_AL_K,
        S_AL_SRCH,
        S_AL_POP,
        S_AL_SPLIT,
        S_AL_DONE,
        S_FR_ORD,
        S_FR_OCHK,
        S_FR_SCAN,
        S_FR_CMP,
        S_FR_SWAP,
        S_FR_PUSH,
        S_ERR
    } state_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] err_reg, err_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.err        = err_reg;
        unique case (state_reg)
            S_BOOT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!sts.is_free)
                begin
                    if (sts.too_large)
                    begin
                        err_next   = ST_TOO_LARGE;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_AL_K;
                    end
                end
                else if (sts.bad_addr)
                begin
                    err_next   = ST_BAD_ADDR;
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.op     = OP_ORD_RD;
                    state_next = S_FR_ORD;
                end
            end
            S_AL_K:
            begin
                if (sts.k_more)
                begin
                    cmd.op = OP_K_STEP;
                end
                else
                begin
                    cmd.op     = OP_I_INIT;
                    state_next = S_AL_SRCH;
                end
            end
            S_AL_SRCH:
            begin
                if (sts.i_over)
                begin
                    err_next   = ST_NO_FREE;
                    state_next = S_ERR;
                end
                else if (sts.cnt_zero)
                begin
                    cmd.op = OP_I_STEP;
                end
                else
                begin
                    cmd.op     = OP_POP_RD;
                    state_next = S_AL_POP;
                end
            end
            S_AL_POP:
            begin
                cmd.op     = OP_POP_TAKE;
                state_next = S_AL_SPLIT;
            end
            S_AL_SPLIT:
            begin
                if (sts.i_gt_k)
                begin
                    cmd.op = OP_SPLIT;
                end
                else
                begin
                    state_next = S_AL_DONE;
                end
            end
            S_AL_DONE:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_ALLOC_DONE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FR_ORD:
            begin
                cmd.op     = OP_ORD_TAKE;
                state_next = S_FR_OCHK;
            end
            S_FR_OCHK:
            begin
                if (sts.o_gt_t)
                begin
                    err_next   = ST_BAD_ADDR;
                    state_next = S_ERR;
                end
                else if (sts.o_lt_t)
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = S_FR_SCAN;
                end
                else
                begin
                    state_next = S_FR_PUSH;
                end
            end
            S_FR_SCAN:
            begin
                if (sts.j_lt_cnt)
                begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_FR_CMP;
                end
                else
                begin
                    state_next = S_FR_PUSH;
                end
            end
            S_FR_CMP:
            begin
                if (sts.match)
                begin
                    cmd.op     = OP_LAST_RD;
                    state_next = S_FR_SWAP;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_FR_SCAN;
                end
            end
            S_FR_SWAP:
            begin
                cmd.op     = OP_SWAP;
                state_next = S_FR_OCHK;
            end
            S_FR_PUSH:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_PUSH_DONE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_ERR;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            out_valid_reg <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

endmodule

@@ rtl/core/buddy_block_allocator.sv @@
// Buddy allocator over a pool of (1 << granule_log2) << top_order bytes, one
// transaction in at a time. An allocate transaction steps up to the chosen
// order k, skips the empty orders above it, pops a free block and pushes one
// split half for each order it splits down; the order walk and the
// single-port free-stack memory serialise these steps. A free transaction
// searches the stack memory for the buddy one entry at a time (issue a read,
// then compare the registered data) and merges each buddy it finds. A new
// transaction is taken while a finished result still waits on the output
// register. After reset the block seeds the top-order free stack in a boot
// state before it accepts anything; any configuration write reseeds the
// stacks in the same cycle.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_ORDER = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [ADDR_W-1:0]     user_address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ADDR_W-1:0]     result_address,
    output logic [ORDF_W-1:0]     block_order,
    output logic [STAT_W-1:0]     status
);

    bba_cmd_t cmd;
    bba_sts_t sts;

    // The controller sequences each transaction; the datapath owns the
    // configuration, the free stacks, the per-granule order table and the
    // result register.
    bba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bba_dpath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .opcode         (opcode),
        .request_size   (request_size),
        .user_address   (user_address),
        .sts            (sts),
        .result_address (result_address),
        .block_order    (block_order),
        .status         (status)
    );

    // An error result never carries an address or an order.
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_address == '0 && block_order == '0)
        else $error("error result carries address or order");

    // Input is captured only on an accepted transaction.
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |-> in_valid && !in_stall)
        else $error("input captured without a transaction");

    // A result is written only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ALLOC_DONE || cmd.op == OP_PUSH_DONE || cmd.op == OP_ERR)
        |-> !out_valid || !out_stall)
        else $error("result overwrote a pending result");

endmodule
